/* hdl/pfn_pkg.sv */
// pfn_pkg: shared constants, status codes, queue entry and state types
// for the polygon face normal block; no dependencies
package pfn_pkg;

  localparam int MaxVertices = 16;
  localparam int CoordBits   = 24;
  localparam int NormalBits  = 16;
  localparam int SumBits     = 56;
  localparam int NormTop     = 30;
  localparam int QueueDepth  = 2;
  localparam int SqW         = 64;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FEW  = 2'd1,
    STAT_ZERO = 2'd2,
    STAT_MANY = 2'd3
  } pfn_status_e;

  typedef struct packed {
    logic [SumBits-1:0] sum_x;
    logic [SumBits-1:0] sum_y;
    logic [SumBits-1:0] sum_z;
    pfn_status_e        status;
  } pfn_entry_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_PUSH
  } pfn_front_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_LOAD,
    B_NORM,
    B_SQ,
    B_SQRT,
    B_DSET,
    B_DIV,
    B_DONE
  } pfn_back_e;

endpackage

/* hdl/pfn_front.sv */
// pfn_front: takes vertices, keeps the last two and the cross product sums
// uses pfn_pkg; feeds one entry per polygon into pfn_fifo
module pfn_front #(
  parameter int COORD_BITS   = pfn_pkg::CoordBits,
  parameter int MAX_VERTICES = pfn_pkg::MaxVertices
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    vtx_valid_i,
  output logic                    vtx_ready_o,
  input  logic [3*COORD_BITS-1:0] vtx_i,
  input  logic                    last_i,
  output logic                    push_o,
  output pfn_pkg::pfn_entry_t     entry_o,
  input  logic                    full_i
);
  import pfn_pkg::*;

  localparam int AW  = COORD_BITS + 1;
  localparam int PW  = 2 * AW;
  localparam int CRW = PW + 1;
  localparam int WW  = (CRW > SumBits) ? CRW : SumBits;
  localparam int CW  = $clog2(MAX_VERTICES + 2);

  pfn_front_e st_q, st_d;
  logic signed [COORD_BITS-1:0] older_q [3];
  logic signed [COORD_BITS-1:0] prior_q [3];
  logic signed [COORD_BITS-1:0] cur [3];
  logic signed [AW-1:0] a_q [3];
  logic signed [AW-1:0] b_q [3];
  logic [SumBits-1:0] sum_q [3];
  logic [CW-1:0] cnt_q;
  logic [1:0] idx_q;
  logic last_q;
  logic accept, contrib;
  logic signed [AW-1:0] pa, pb, pc, pd;
  logic signed [PW-1:0] p0, p1;
  logic signed [CRW-1:0] cr;
  logic signed [WW-1:0] cr_w;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cur[k] = vtx_i[k*COORD_BITS +: COORD_BITS];
    end
  end

  assign vtx_ready_o = (st_q == F_IDLE);
  assign accept      = vtx_valid_i && vtx_ready_o;
  assign contrib     = (cnt_q >= CW'(2)) && (cnt_q < CW'(MAX_VERTICES));

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      F_IDLE: begin
        if (accept) begin
          if (contrib) st_d = F_MUL;
          else if (last_i) st_d = F_PUSH;
        end
      end
      F_MUL: begin
        if (idx_q == 2'd2) st_d = last_q ? F_PUSH : F_IDLE;
      end
      F_PUSH: begin
        if (!full_i) st_d = F_IDLE;
      end
      default: st_d = F_IDLE;
    endcase
  end

  always_comb begin
    push_o         = (st_q == F_PUSH) && !full_i;
    entry_o.sum_x  = sum_q[0];
    entry_o.sum_y  = sum_q[1];
    entry_o.sum_z  = sum_q[2];
    if (cnt_q < CW'(3)) entry_o.status = STAT_FEW;
    else if (cnt_q > CW'(MAX_VERTICES)) entry_o.status = STAT_MANY;
    else entry_o.status = STAT_OK;
  end

  // one cross product component per cycle
  always_comb begin
    unique case (idx_q)
      2'd0: begin
        pa = a_q[1]; pb = b_q[2]; pc = a_q[2]; pd = b_q[1];
      end
      2'd1: begin
        pa = a_q[2]; pb = b_q[0]; pc = a_q[0]; pd = b_q[2];
      end
      2'd2: begin
        pa = a_q[0]; pb = b_q[1]; pc = a_q[1]; pd = b_q[0];
      end
      default: begin
        pa = '0; pb = '0; pc = '0; pd = '0;
      end
    endcase
    p0   = pa * pb;
    p1   = pc * pd;
    cr   = CRW'(p0) - CRW'(p1);
    cr_w = WW'(cr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= F_IDLE;
      cnt_q  <= '0;
      idx_q  <= '0;
      last_q <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        older_q[k] <= '0;
        prior_q[k] <= '0;
        sum_q[k]   <= '0;
      end
    end else begin
      st_q <= st_d;
      unique case (st_q)
        F_IDLE: begin
          if (accept) begin
            for (int k = 0; k < 3; k++) begin
              older_q[k] <= prior_q[k];
              prior_q[k] <= cur[k];
            end
            if (cnt_q <= CW'(MAX_VERTICES)) cnt_q <= cnt_q + CW'(1);
            last_q <= last_i;
            idx_q  <= '0;
          end
        end
        F_MUL: begin
          sum_q[idx_q] <= sum_q[idx_q] + cr_w[SumBits-1:0];
          idx_q        <= idx_q + 2'd1;
        end
        F_PUSH: begin
          if (!full_i) begin
            cnt_q  <= '0;
            last_q <= 1'b0;
            for (int k = 0; k < 3; k++) begin
              older_q[k] <= '0;
              prior_q[k] <= '0;
              sum_q[k]   <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // difference vectors, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int k = 0; k < 3; k++) begin
        a_q[k] <= AW'(prior_q[k]) - AW'(older_q[k]);
        b_q[k] <= AW'(cur[k]) - AW'(older_q[k]);
      end
    end
  end

endmodule

/* hdl/pfn_fifo.sv */
// pfn_fifo: short queue of finished polygon sums between front and back
// uses pfn_pkg for the entry type and depth
module pfn_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  pfn_pkg::pfn_entry_t entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output pfn_pkg::pfn_entry_t entry_o
);
  import pfn_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  pfn_entry_t mem_q [QueueDepth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign entry_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (wp_q == PtrW'(QueueDepth - 1)) ? '0 : wp_q + PtrW'(1);
      if (pop_i) rp_q <= (rp_q == PtrW'(QueueDepth - 1)) ? '0 : rp_q + PtrW'(1);
      if (push_i && !pop_i) cnt_q <= cnt_q + CntW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CntW'(1);
    end
  end

endmodule

/* hdl/pfn_back.sv */
// pfn_back: normalizes one polygon sum to a unit normal with a shift stage,
// a serial square root and a serial divider; uses pfn_pkg
module pfn_back #(
  parameter int NORMAL_BITS = pfn_pkg::NormalBits
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       empty_i,
  input  pfn_pkg::pfn_entry_t        entry_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [NORMAL_BITS-1:0]     normal_x_o,
  output logic [NORMAL_BITS-1:0]     normal_y_o,
  output logic [NORMAL_BITS-1:0]     normal_z_o,
  output pfn_pkg::pfn_status_e       status_o
);
  import pfn_pkg::*;

  localparam int NB   = NORMAL_BITS;
  localparam int NUMW = NormTop + 1 + NB;
  localparam int RW   = 34;
  localparam int DCW  = $clog2(NB + 2);

  pfn_back_e st_q, st_d;
  pfn_status_e code_q, ostat_q;
  logic neg_q [3];
  logic [SumBits-1:0] m_q [3];
  logic [SqW-1:0] v_q, res_q, bit_q;
  logic [31:0] len_q;
  logic [1:0] idx_q;
  logic [RW-1:0] rem_q;
  logic [NB:0] num_q, q_q;
  logic [DCW-1:0] dcnt_q;
  logic [NB-1:0] nrm_q [3];
  logic [NB-1:0] onrm_q [3];
  logic ovalid_q;
  logic [SumBits-1:0] s_in [3];

  logic out_free, hi, lo, all_zero, sq_ge, dv_ge;
  logic [2*NormTop-1:0] prod;
  logic [SqW-1:0] trial, res_n;
  logic [NUMW-1:0] num;
  logic [RW-1:0] t, dvs;
  logic [NB:0] qn;
  logic [NB-1:0] mag, sres;

  assign out_free = !ovalid_q || out_ready_i;
  assign s_in[0]  = entry_i.sum_x;
  assign s_in[1]  = entry_i.sum_y;
  assign s_in[2]  = entry_i.sum_z;

  always_comb begin
    hi       = 1'b0;
    lo       = 1'b1;
    all_zero = 1'b1;
    for (int k = 0; k < 3; k++) begin
      hi       = hi | (|m_q[k][SumBits-1:NormTop]);
      lo       = lo & ~(|m_q[k][SumBits-1:NormTop-1]);
      all_zero = all_zero & ~(|m_q[k]);
    end
    prod  = m_q[idx_q][NormTop-1:0] * m_q[idx_q][NormTop-1:0];
    trial = res_q + bit_q;
    sq_ge = (v_q >= trial);
    res_n = sq_ge ? ((res_q >> 1) + bit_q) : (res_q >> 1);
    num   = (NUMW'(m_q[idx_q][NormTop-1:0]) << NB) + NUMW'(len_q);
    t     = {rem_q[RW-2:0], num_q[NB]};
    dvs   = {1'b0, len_q, 1'b0};
    dv_ge = (t >= dvs);
    qn    = {q_q[NB-1:0], dv_ge};
    mag   = (qn > (NB+1)'({(NB-1){1'b1}})) ? {1'b0, {(NB-1){1'b1}}} : qn[NB-1:0];
    sres  = neg_q[idx_q] ? (~mag + NB'(1)) : mag;
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      B_IDLE: if (!empty_i) st_d = B_LOAD;
      B_LOAD: st_d = ((code_q != STAT_OK) || all_zero) ? B_DONE : B_NORM;
      B_NORM: if (!hi && !lo) st_d = B_SQ;
      B_SQ:   if (idx_q == 2'd2) st_d = B_SQRT;
      B_SQRT: if (bit_q[0]) st_d = B_DSET;
      B_DSET: st_d = B_DIV;
      B_DIV:  if (dcnt_q == DCW'(NB)) st_d = (idx_q == 2'd2) ? B_DONE : B_DSET;
      B_DONE: if (out_free) st_d = B_IDLE;
      default: st_d = B_IDLE;
    endcase
  end

  always_comb begin
    pop_o       = (st_q == B_IDLE) && !empty_i;
    out_valid_o = ovalid_q;
    normal_x_o  = onrm_q[0];
    normal_y_o  = onrm_q[1];
    normal_z_o  = onrm_q[2];
    status_o    = ostat_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= B_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == B_DONE && out_free) ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      B_IDLE: begin
        code_q <= entry_i.status;
        for (int k = 0; k < 3; k++) begin
          neg_q[k] <= s_in[k][SumBits-1];
          m_q[k]   <= s_in[k][SumBits-1] ? (~s_in[k] + SumBits'(1)) : s_in[k];
        end
      end
      B_LOAD: begin
        for (int k = 0; k < 3; k++) nrm_q[k] <= '0;
        if (code_q == STAT_OK && all_zero) code_q <= STAT_ZERO;
        idx_q <= '0;
        v_q   <= '0;
      end
      B_NORM: begin
        for (int k = 0; k < 3; k++) begin
          if (hi) m_q[k] <= m_q[k] >> 1;
          else if (lo) m_q[k] <= m_q[k] << 1;
        end
      end
      B_SQ: begin
        v_q   <= v_q + SqW'(prod);
        idx_q <= idx_q + 2'd1;
        res_q <= '0;
        bit_q <= SqW'(1) << 62;
      end
      B_SQRT: begin
        if (sq_ge) v_q <= v_q - trial;
        res_q <= res_n;
        bit_q <= bit_q >> 2;
        idx_q <= '0;
        len_q <= res_n[31:0];
      end
      B_DSET: begin
        rem_q  <= RW'(num[NUMW-1:NB+1]);
        num_q  <= num[NB:0];
        q_q    <= '0;
        dcnt_q <= '0;
      end
      B_DIV: begin
        rem_q  <= dv_ge ? (t - dvs) : t;
        q_q    <= qn;
        num_q  <= num_q << 1;
        dcnt_q <= dcnt_q + DCW'(1);
        if (dcnt_q == DCW'(NB)) begin
          nrm_q[idx_q] <= sres;
          idx_q        <= idx_q + 2'd1;
        end
      end
      B_DONE: begin
        if (out_free) begin
          for (int k = 0; k < 3; k++) onrm_q[k] <= nrm_q[k];
          ostat_q <= code_q;
        end
      end
      default: ;
    endcase
  end

endmodule

/* hdl/polygon_face_normal_top.sv */
// polygon_face_normal_top: unit face normal of a polygon from a vertex stream
// uses pfn_pkg, pfn_front, pfn_fifo and pfn_back
//
// slave stream: one vertex per transfer, x, y, z packed in tdata, tlast
// marks the final vertex of the polygon. master stream: one result per
// polygon, three signed Q1.15 components and a 2-bit status.
// status: 0 ok, 1 under three vertices, 2 zero area, 3 too many vertices;
// any status other than ok comes with all components zero.
// front: a vertex that adds a cross product is accepted and then holds off
// the next vertex while its three components go through the shared
// multiplier pair in turn; the last vertex of a polygon then waits in a
// push state while the queue is full. back: load, normalizing shift, sum of
// squares, serial square root and serial divider, one polygon at a time.
// a two-entry queue lets the front take the next polygon while the back
// still works on the previous one.
// reset clears the sums, the vertex history and both streams' valid state.
// a stalled receiver holds the result; the back then stops and, once the
// queue fills, tready drops.
module polygon_face_normal_top #(
  parameter int  MAX_VERTICES = pfn_pkg::MaxVertices,
  parameter int  COORD_BITS   = pfn_pkg::CoordBits,
  parameter int  NORMAL_BITS  = pfn_pkg::NormalBits,
  localparam int IN_W         = ((3 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W        = ((3 * NORMAL_BITS + 2 + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,  // vertex_x, vertex_y, vertex_z
  input  logic             s_axis_tlast,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata   // normal_x, normal_y, normal_z, status
);
  import pfn_pkg::*;

  logic q_push, q_full, q_pop, q_empty;
  pfn_entry_t q_in, q_out;
  logic [NORMAL_BITS-1:0] nx, ny, nz;
  pfn_status_e stat;

  pfn_front #(
    .COORD_BITS  (COORD_BITS),
    .MAX_VERTICES(MAX_VERTICES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .vtx_valid_i(s_axis_tvalid),
    .vtx_ready_o(s_axis_tready),
    .vtx_i      (s_axis_tdata[3*COORD_BITS-1:0]),
    .last_i     (s_axis_tlast),
    .push_o     (q_push),
    .entry_o    (q_in),
    .full_i     (q_full)
  );

  pfn_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .entry_i(q_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .entry_o(q_out)
  );

  pfn_back #(
    .NORMAL_BITS(NORMAL_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (q_empty),
    .entry_i    (q_out),
    .pop_o      (q_pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .normal_x_o (nx),
    .normal_y_o (ny),
    .normal_z_o (nz),
    .status_o   (stat)
  );

  assign m_axis_tdata = OUT_W'({stat, nz, ny, nx});

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("queue pop while empty");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && stat != STAT_OK) |-> (nx == '0 && ny == '0 && nz == '0))
    else $error("nonzero normal with failing status");

endmodule

/* dv/polygon_face_normal_top_tb.sv */
// polygon_face_normal_top_tb: random and directed polygons streamed into the face normal
// block, results checked against an internal predictor; uses pfn_pkg and
// polygon_face_normal_top
`timescale 1ns / 1ps

class normal_scoreboard;
  localparam int MaxV = pfn_pkg::MaxVertices;
  longint      older_v[3];
  longint      prior_v[3];
  longint      area_sum[3];
  int          vtx_count;
  logic [55:0] normal_q[$];
  int          mismatches;
  int          results;
  int          polygons;

  function new();
    clear();
    mismatches = 0;
    results    = 0;
    polygons   = 0;
  endfunction

  function void clear();
    for (int i = 0; i < 3; i++) begin
      older_v[i]  = 0;
      prior_v[i]  = 0;
      area_sum[i] = 0;
    end
    vtx_count = 0;
  endfunction

  function longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function void note_vertex(logic [71:0] data, bit last);
    logic signed [23:0] c24;
    longint             cur[3];
    longint             a[3];
    longint             b[3];
    longint             cr[3];
    longint             t;
    longint unsigned    m[3];
    longint unsigned    maxm;
    longint unsigned    sq;
    longint unsigned    len;
    longint unsigned    q;
    longint             res[3];
    int                 blen;
    pfn_pkg::pfn_status_e st;
    for (int i = 0; i < 3; i++) begin
      c24    = data[24*i +: 24];
      cur[i] = c24;
    end
    if (vtx_count >= 2 && vtx_count < MaxV) begin
      for (int i = 0; i < 3; i++) begin
        a[i] = prior_v[i] - older_v[i];
        b[i] = cur[i] - older_v[i];
      end
      cr[0] = a[1] * b[2] - a[2] * b[1];
      cr[1] = a[2] * b[0] - a[0] * b[2];
      cr[2] = a[0] * b[1] - a[1] * b[0];
      for (int i = 0; i < 3; i++) begin
        t           = area_sum[i] + cr[i];
        area_sum[i] = (t <<< 8) >>> 8;
      end
    end
    if (vtx_count <= MaxV) vtx_count++;
    for (int i = 0; i < 3; i++) begin
      older_v[i] = prior_v[i];
      prior_v[i] = cur[i];
    end
    if (!last) return;
    polygons++;
    res = '{0, 0, 0};
    if (vtx_count < 3) begin
      st = pfn_pkg::STAT_FEW;
    end else if (vtx_count > MaxV) begin
      st = pfn_pkg::STAT_MANY;
    end else if (area_sum[0] == 0 && area_sum[1] == 0 && area_sum[2] == 0) begin
      st = pfn_pkg::STAT_ZERO;
    end else begin
      st   = pfn_pkg::STAT_OK;
      maxm = 0;
      sq   = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = (area_sum[i] < 0) ? -area_sum[i] : area_sum[i];
        if (m[i] > maxm) maxm = m[i];
      end
      blen = 0;
      while (blen < 64 && (maxm >> blen) != 0) blen++;
      for (int i = 0; i < 3; i++) begin
        if (blen > pfn_pkg::NormTop) m[i] = m[i] >> (blen - pfn_pkg::NormTop);
        else m[i] = m[i] << (pfn_pkg::NormTop - blen);
        sq = sq + m[i] * m[i];
      end
      len = int_sqrt(sq);
      for (int i = 0; i < 3; i++) begin
        q = (2 * m[i] * 32768 + len) / (2 * len);
        if (q > 32767) q = 32767;
        res[i] = (area_sum[i] < 0) ? -longint'(q) : longint'(q);
      end
    end
    normal_q.push_back({6'd0, st, res[2][15:0], res[1][15:0], res[0][15:0]});
    clear();
  endfunction

  function void check_result(logic [55:0] got);
    logic [55:0] want;
    bit          bad;
    results++;
    if (normal_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    want = normal_q.pop_front();
    bad  = 0;
    for (int i = 0; i < 3; i++)
      if (got[16*i +: 16] !== want[16*i +: 16]) bad = 1;
    if (got[49:48] !== want[49:48]) bad = 1;
    if (bad) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: exp x=%h y=%h z=%h st=%0d got x=%h y=%h z=%h st=%0d",
                 results, want[15:0], want[31:16], want[47:32], want[49:48],
                 got[15:0], got[31:16], got[47:32], got[49:48]);
    end
  endfunction
endclass

module polygon_face_normal_top_tb;
  import pfn_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;

  normal_scoreboard sb;
  int  cycles;
  int  vertices_sent;
  int  burst_left;
  int  stall_mode;
  int  stall_phase;

  polygon_face_normal_top uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial clk_i = 0;
  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 1500000) begin
      $display("FAIL polygon_face_normal_top");
      $finish;
    end
  end

  // receiver with its own stall pattern, switching style now and then
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    stall_phase <= stall_phase + 1;
    if ($urandom_range(0, 299) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 9) < 7);
      2: m_axis_tready <= (stall_phase % 7) < 3;
      default: m_axis_tready <= ($urandom_range(0, 9) < 2);
    endcase
  end

  task automatic put_vertex(logic signed [23:0] x, logic signed [23:0] y,
                            logic signed [23:0] z, bit last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {z, y, x};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_vertex({z, y, x}, last);
    vertices_sent++;
  endtask

  function automatic logic signed [23:0] pick_coord(int kind);
    case (kind)
      0: return 24'($urandom());
      1: return 24'($urandom_range(0, 8000) - 4000);
      2: return ($urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000);
      default: return 24'($urandom_range(0, 400000) - 200000);
    endcase
  endfunction

  task automatic random_polygon(int n, int kind);
    for (int i = 0; i < n; i++)
      put_vertex(pick_coord(kind), pick_coord(kind), pick_coord(kind), i == n - 1);
  endtask

  // points along one line, or one point repeated, close with zero area
  task automatic flat_polygon(int n);
    logic signed [23:0] bx, by, bz, dx, dy, dz;
    bx = pick_coord(3);
    by = pick_coord(3);
    bz = pick_coord(3);
    dx = 24'($urandom_range(0, 200) - 100);
    dy = 24'($urandom_range(0, 200) - 100);
    dz = $urandom_range(0, 1) ? 24'sd0 : 24'($urandom_range(0, 200) - 100);
    for (int i = 0; i < n; i++)
      put_vertex(24'(bx + i * dx), 24'(by + i * dy), 24'(bz + i * dz), i == n - 1);
  endtask

  initial begin
    int n;
    int r;
    sb            = new();
    cycles        = 0;
    vertices_sent = 0;
    burst_left    = 0;
    stall_mode    = 0;
    stall_phase   = 0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    rst_ni        = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single vertex, two vertices, tiny triangle
    put_vertex(24'sd5, -24'sd3, 24'sd1, 1);
    put_vertex(24'sd0, 24'sd0, 24'sd0, 0);
    put_vertex(24'sd4096, 24'sd0, 24'sd0, 1);
    put_vertex(24'sd0, 24'sd0, 24'sd0, 0);
    put_vertex(24'sd1, 24'sd0, 24'sd0, 0);
    put_vertex(24'sd0, 24'sd1, 24'sd0, 1);
    // extreme corners
    put_vertex(24'sh800000, 24'sh800000, 24'sh7fffff, 0);
    put_vertex(24'sh7fffff, 24'sh800000, 24'sh800000, 0);
    put_vertex(24'sh800000, 24'sh7fffff, 24'sh800000, 1);
    // collinear, zero area
    flat_polygon(4);
    // largest accepted size, then one too many
    random_polygon(16, 3);
    random_polygon(17, 1);

    while (vertices_sent < 1150) begin
      r = $urandom_range(0, 99);
      if (r < 78) begin
        n = $urandom_range(3, 10);
        random_polygon(n, $urandom_range(0, 3));
      end else if (r < 86) begin
        random_polygon($urandom_range(1, 2), $urandom_range(0, 3));
      end else if (r < 93) begin
        random_polygon($urandom_range(15, 20), $urandom_range(0, 3));
      end else begin
        flat_polygon($urandom_range(3, 8));
      end
    end
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;

    while (sb.normal_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);

    $display("sent %0d vertices in %0d polygons, checked %0d normals, %0d mismatches",
             vertices_sent, sb.polygons, sb.results, sb.mismatches);
    if (sb.mismatches == 0 && sb.normal_q.size() == 0) begin
      $display("PASS polygon_face_normal_top");
    end else begin
      $display("FAIL polygon_face_normal_top");
    end
    $finish;
  end
endmodule

/* filelist.f */
hdl/pfn_pkg.sv
hdl/pfn_front.sv
hdl/pfn_fifo.sv
hdl/pfn_back.sv
hdl/polygon_face_normal_top.sv
dv/polygon_face_normal_top_tb.sv
